### hw/rtl/sprq_pkg.sv
// ----------------------------------------------------------------------------
// sprq_pkg
// Shared types and codes for the sorted priority ready queue unit.
// ----------------------------------------------------------------------------
package sprq_pkg;

	localparam int ID_W     = 6;
	localparam int PRIO_W   = 3;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = ID_W + PRIO_W;

	localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic push_step;
		logic walk_step;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic go_push;
		logic go_walk;
		logic push_done;
		logic walk_done;
	} dp_stat_t;

endpackage

### hw/rtl/sprq_ram.sv
// ----------------------------------------------------------------------------
// sprq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sprq_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/sprq_datapath.sv
// ----------------------------------------------------------------------------
// sprq_datapath
// Entry store, occupancy, walk pointer and result registers of the queue.
// ----------------------------------------------------------------------------
module sprq_datapath #(
	parameter int CAPACITY = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sprq_pkg::dp_cmd_t               cmd,
	output sprq_pkg::dp_stat_t              stat,
	input  logic [sprq_pkg::KIND_W-1:0]     kind,
	input  logic [sprq_pkg::ID_W-1:0]       proc_id,
	input  logic [sprq_pkg::PRIO_W-1:0]     prio,
	output logic [sprq_pkg::ID_W-1:0]       out_id,
	output logic [sprq_pkg::STATUS_W-1:0]   status,
	output logic                            now_empty
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] occ_q;
	logic [CW-1:0] ptr_q;
	logic          found_q;

	logic                            is_pop_q;
	logic [sprq_pkg::ID_W-1:0]       id_q;
	logic [sprq_pkg::PRIO_W-1:0]     prio_q;
	logic [sprq_pkg::ID_W-1:0]       got_q;
	logic [sprq_pkg::STATUS_W-1:0]   res_q;
	logic [sprq_pkg::ID_W-1:0]       out_id_q;
	logic [sprq_pkg::STATUS_W-1:0]   status_q;
	logic                            now_empty_q;

	logic                 we;
	logic [AW-1:0]        waddr;
	logic [AW-1:0]        raddr;
	sprq_pkg::entry_t     wdata;
	sprq_pkg::entry_t     rd;
	logic [sprq_pkg::ENTRY_W-1:0] rdata;

	logic full;
	logic empty;
	logic push_shift;
	logic walk_last;
	logic walk_hit;
	logic is_push_in;
	logic is_walk_in;

	sprq_ram #(
		.WIDTH(sprq_pkg::ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd = sprq_pkg::entry_t'(rdata);

	assign full       = (occ_q == CW'(CAPACITY));
	assign empty      = (occ_q == '0);
	assign is_push_in = (kind == sprq_pkg::KIND_PUSH);
	assign is_walk_in = (kind == sprq_pkg::KIND_POP) || (kind == sprq_pkg::KIND_REMOVE);

	// push walks back from the tail, moving up entries of equal or greater priority
	assign push_shift = (ptr_q != '0) && (rd.prio >= prio_q);
	assign walk_last  = (ptr_q == occ_q - CW'(1));
	assign walk_hit   = is_pop_q || (rd.id == id_q);

	assign stat.go_push   = is_push_in && !full;
	assign stat.go_walk   = is_walk_in && !empty;
	assign stat.push_done = !push_shift;
	assign stat.walk_done = walk_last;

	always_comb begin
		raddr = '0;
		if (cmd.accept) begin
			if (is_push_in && !empty) begin
				raddr = AW'(occ_q - CW'(1));
			end
		end else if (cmd.push_step) begin
			if (ptr_q >= CW'(2)) begin
				raddr = AW'(ptr_q - CW'(2));
			end
		end else if (cmd.walk_step) begin
			if (ptr_q < CW'(CAPACITY - 1)) begin
				raddr = AW'(ptr_q + CW'(1));
			end
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = rd;
		if (cmd.push_step) begin
			we    = 1'b1;
			waddr = AW'(ptr_q);
			if (!push_shift) begin
				wdata.id   = id_q;
				wdata.prio = prio_q;
			end
		end else if (cmd.walk_step) begin
			// once the victim is found, each later entry moves down one slot
			we    = found_q;
			waddr = AW'(ptr_q - CW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			ptr_q   <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				found_q <= 1'b0;
				ptr_q   <= is_push_in ? occ_q : '0;
			end else if (cmd.push_step) begin
				if (push_shift) begin
					ptr_q <= ptr_q - CW'(1);
				end else begin
					occ_q <= occ_q + CW'(1);
				end
			end else if (cmd.walk_step) begin
				ptr_q <= ptr_q + CW'(1);
				if (walk_hit) begin
					found_q <= 1'b1;
				end
				if (walk_last && (found_q || walk_hit)) begin
					occ_q <= occ_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			is_pop_q <= (kind == sprq_pkg::KIND_POP);
			id_q     <= proc_id;
			prio_q   <= prio;
			got_q    <= '0;
			if (is_push_in) begin
				res_q <= full ? sprq_pkg::ST_FULL : sprq_pkg::ST_OK;
			end else if (is_walk_in) begin
				res_q <= empty ? sprq_pkg::ST_EMPTY : sprq_pkg::ST_OK;
			end else begin
				res_q <= sprq_pkg::ST_OK;
			end
		end else if (cmd.walk_step) begin
			if (!found_q && walk_hit && is_pop_q) begin
				got_q <= rd.id;
			end
			if (walk_last && !found_q && !walk_hit) begin
				res_q <= sprq_pkg::ST_NOT_FOUND;
			end
		end
		if (cmd.load_out) begin
			out_id_q    <= got_q;
			status_q    <= res_q;
			now_empty_q <= (occ_q == '0);
		end
	end

	assign out_id    = out_id_q;
	assign status    = status_q;
	assign now_empty = now_empty_q;

`ifndef NO_ASSERTIONS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(CAPACITY))
		else $error("occupancy above capacity");

	a_push_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_step |-> (ptr_q <= occ_q) && (occ_q < CW'(CAPACITY)))
		else $error("push pointer outside the filled range");

	a_walk_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> (ptr_q < occ_q))
		else $error("walk pointer past the last entry");

	a_occ_change: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != $past(occ_q)) |-> $past(cmd.push_step || cmd.walk_step))
		else $error("occupancy changed outside a push or walk step");
`endif

endmodule

### hw/rtl/sprq_ctrl.sv
// ----------------------------------------------------------------------------
// sprq_ctrl
// Sequencer for the queue: accept, push walk, remove/pop walk, result hand-off.
// ----------------------------------------------------------------------------
module sprq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output sprq_pkg::dp_cmd_t   cmd,
	input  sprq_pkg::dp_stat_t  stat
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PUSH = 4'b0010,
		S_WALK = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);

	assign cmd.accept    = (state_q == S_IDLE) && in_valid;
	assign cmd.push_step = (state_q == S_PUSH);
	assign cmd.walk_step = (state_q == S_WALK);
	assign cmd.load_out  = (state_q == S_FIN) && slot_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (stat.go_push) begin
						state_d = S_PUSH;
					end else if (stat.go_walk) begin
						state_d = S_WALK;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_PUSH: begin
				if (stat.push_done) begin
					state_d = S_FIN;
				end
			end
			S_WALK: begin
				if (stat.walk_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hw/rtl/sorted_priority_ready_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_ready_queue_unit
// Bounded queue of process identifiers kept sorted by priority (lower first).
// ----------------------------------------------------------------------------
//  channel | signals                          | handshake
//  --------+----------------------------------+------------------------------
//  in      | kind, proc_id, prio              | in_valid / in_stall
//  out     | out_id, status, now_empty        | out_valid / out_stall
//
// An item is accepted, then the entries are visited one at a time on the single
// read port of the entry RAM (a push visits the entries at or above its
// priority and then writes itself in, a pop or remove visits all of them),
// then the result is loaded. Full, empty and unused kinds skip the visits.
// The RAM is not cleared at reset; occupancy, walk pointer, flags and state are.
// A stalled result waits in the output register; the next item is accepted
// meanwhile and holds its result until that register frees.
module sorted_priority_ready_queue_unit #(
	parameter int CAPACITY = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [sprq_pkg::KIND_W-1:0]     kind,
	input  logic [sprq_pkg::ID_W-1:0]       proc_id,
	input  logic [sprq_pkg::PRIO_W-1:0]     prio,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [sprq_pkg::ID_W-1:0]       out_id,
	output logic [sprq_pkg::STATUS_W-1:0]   status,
	output logic                            now_empty
);

	sprq_pkg::dp_cmd_t  cmd;
	sprq_pkg::dp_stat_t stat;

	sprq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	sprq_datapath #(
		.CAPACITY(CAPACITY)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.kind     (kind),
		.proc_id  (proc_id),
		.prio     (prio),
		.out_id   (out_id),
		.status   (status),
		.now_empty(now_empty)
	);

endmodule
